@@ rtl/pbg_pkg.sv @@
// Shared types, widths, constants and the linearization table for the brightness pipeline.
package pbg_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORK_BITS = 24;
  localparam int unsigned BRIGHT_W  = FRAC_BITS + 1;
  localparam int unsigned RND_SH    = WORK_BITS - FRAC_BITS;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned LIN_W  = 16;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned PROD_W = LIN_W + COEF_W;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned COMP_W = ACC_W - (WORK_BITS - LIN_W);
  localparam int unsigned SQ_W   = 2 * COMP_W;
  localparam int unsigned S_W    = SQ_W + 2;
  localparam int unsigned ROOT_W = S_W / 2;

  // Square root: one result bit per iteration, two iterations per stage.
  localparam int unsigned SQ_ITERS     = S_W / 2;
  localparam int unsigned SQ_PER_STAGE = 2;
  localparam int unsigned SQ_STAGES    = SQ_ITERS / SQ_PER_STAGE;

  localparam int unsigned N_LEVELS = 7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [2:0]          level;
  } result_t;

  // Row-major sRGB-to-XYZ matrix, Q0.16.
  localparam logic [COEF_W-1:0] COEF [9] = '{
    16'd27031, 16'd23434, 16'd11825,
    16'd13938, 16'd46868, 16'd4730,
    16'd1267,  16'd7811,  16'd62279
  };

  // Level thresholds on the vector length, Q.24.
  localparam logic [63:0] THRESH [N_LEVELS] = '{
    64'd3685820, 64'd7371640, 64'd11057477, 64'd14743297,
    64'd18429117, 64'd22114954, 64'd25800775
  };

  typedef logic [255:0][LIN_W-1:0] lin_rom_t;

  // One table entry of the sRGB transfer curve, evaluated at elaboration.
  function automatic logic [LIN_W-1:0] rom_entry(int unsigned i);
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] val;
    int k;
    if (i <= 10) begin
      val = (64'(i) * 64'd13107200 + 64'd329460) / 64'd658920;
      return val[LIN_W-1:0];
    end
    if (i >= 255) begin
      return 16'hFFFF;
    end
    num = 64'd1000 * 64'(i) + 64'd14025;
    t   = ((num << 32) + 64'd134512) / 64'd269025;
    u   = (t * t) >> 32;
    lo  = 64'd0;
    hi  = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      p = mid;
      for (k = 0; k < 4; k++) begin
        p = (p * mid) >> 32;
      end
      if (p <= u) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    v   = (u * lo) >> 32;
    val = (v + 64'd32768) >> 16;
    if (val > 64'd65535) begin
      val = 64'd65535;
    end
    return val[LIN_W-1:0];
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = rom_entry(i);
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

@@ rtl/pbg_sqrt.sv @@
// Pipelined integer square root, two result bits per register stage.
module pbg_sqrt (
  input  logic                        clk,
  input  logic [pbg_pkg::SQ_STAGES-1:0] adv,
  input  logic [pbg_pkg::S_W-1:0]     s_in,
  output logic [pbg_pkg::ROOT_W-1:0]  root
);

  localparam int unsigned SW  = pbg_pkg::S_W;
  localparam int unsigned NST = pbg_pkg::SQ_STAGES;

  logic [SW-1:0] rem_r [NST];
  logic [SW-1:0] res_r [NST];
  logic [SW-1:0] rem_in [NST];
  logic [SW-1:0] res_in [NST];
  logic [SW-1:0] rem_nxt [NST];
  logic [SW-1:0] res_nxt [NST];

  assign rem_in[0] = s_in;
  assign res_in[0] = '0;

  for (genvar st = 0; st < NST; st++) begin : g_stage
    localparam int unsigned K0 = pbg_pkg::SQ_ITERS - 1 - st * pbg_pkg::SQ_PER_STAGE;

    if (st > 0) begin : g_link
      assign rem_in[st] = rem_r[st-1];
      assign res_in[st] = res_r[st-1];
    end

    always_comb begin
      logic [SW-1:0] rem;
      logic [SW-1:0] res;
      logic [SW-1:0] b;
      logic [SW:0]   trial;
      rem = rem_in[st];
      res = res_in[st];
      for (int j = 0; j < pbg_pkg::SQ_PER_STAGE; j++) begin
        b     = SW'(1) << (2 * (K0 - j));
        trial = {1'b0, res} + {1'b0, b};
        if ({1'b0, rem} >= trial) begin
          rem = rem - trial[SW-1:0];
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
      end
      rem_nxt[st] = rem;
      res_nxt[st] = res;
    end

    always_ff @(posedge clk) begin
      if (adv[st]) begin
        rem_r[st] <= rem_nxt[st];
        res_r[st] <= res_nxt[st];
      end
    end
  end

  assign root = res_r[NST-1][pbg_pkg::ROOT_W-1:0];

endmodule

@@ rtl/pixel_brightness_glyph_level.sv @@
// Top level: sRGB pixel to XYZ vector length and glyph level, fully pipelined.
//
// Input channel: in_valid/in_ready carry one pixel beat (red, green, blue bytes).
// Output channel: out_valid/out_ready carry one result beat per pixel: the XYZ
// length in unsigned Q1.16 (saturating) and a level 0..7 from seven thresholds.
// cfg_we writes cfg_wdata into the invert register; write it only while idle.
// When set, each channel becomes 255 minus itself before the transfer curve.
//
// The pipeline has 20 register stages: table lookup, matrix products, matrix
// sums, squares, sum of squares, 14 square-root stages of two bits each, and
// the output register. One beat is accepted every cycle while the receiver
// takes results or any stage is empty; each stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up
// and a stalled receiver holds only the beats that cannot advance.
// Synchronous reset clears the valid bits and the invert register; the
// pipeline payload is not reset.
module pixel_brightness_glyph_level (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbg_pkg::pixel_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pbg_pkg::result_t  out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int unsigned ST_LIN   = 0;
  localparam int unsigned ST_PROD  = 1;
  localparam int unsigned ST_COMP  = 2;
  localparam int unsigned ST_SQ    = 3;
  localparam int unsigned ST_SUM   = 4;
  localparam int unsigned ST_ROOT0 = 5;
  localparam int unsigned ST_OUT   = ST_ROOT0 + pbg_pkg::SQ_STAGES;
  localparam int unsigned NST      = ST_OUT + 1;

  localparam int unsigned SUM_W   = pbg_pkg::ROOT_W + 1;
  localparam logic [SUM_W-1:0] HALF  = SUM_W'((64'd1 << pbg_pkg::RND_SH) >> 1);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'((64'd1 << pbg_pkg::BRIGHT_W) - 64'd1);

  logic                          invert_r;
  logic [NST-1:0]                valid_r;
  logic [NST:0]                  rdy;

  logic [pbg_pkg::LIN_W-1:0]     lin_r  [3];
  logic [pbg_pkg::PROD_W-1:0]    prod_r [9];
  logic [pbg_pkg::COMP_W-1:0]    comp_r [3];
  logic [pbg_pkg::SQ_W-1:0]      sq_r   [3];
  logic [pbg_pkg::S_W-1:0]       sum_r;
  logic [2:0]                    level_r [pbg_pkg::SQ_STAGES];
  pbg_pkg::result_t              out_r;

  logic [pbg_pkg::CH_W-1:0]      ch [3];
  logic [2:0]                    level_nxt;
  logic [pbg_pkg::ROOT_W-1:0]    root;
  logic [SUM_W-1:0]              rounded;
  pbg_pkg::result_t              out_nxt;

  // A stage may load when it is empty or its content moves on this cycle.
  assign rdy[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = !valid_r[i] || rdy[i+1];
  end

  assign in_ready  = rdy[ST_LIN];
  assign out_valid = valid_r[ST_OUT];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      if (cfg_we) begin
        invert_r <= cfg_wdata;
      end
      if (rdy[ST_LIN]) begin
        valid_r[ST_LIN] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  assign ch[0] = invert_r ? ~in_data.red   : in_data.red;
  assign ch[1] = invert_r ? ~in_data.green : in_data.green;
  assign ch[2] = invert_r ? ~in_data.blue  : in_data.blue;

  // Front stages: table lookup, matrix products, rounded row sums, squares, sum.
  always_ff @(posedge clk) begin
    logic [pbg_pkg::ACC_W-1:0] acc;
    if (rdy[ST_LIN]) begin
      for (int c = 0; c < 3; c++) begin
        lin_r[c] <= pbg_pkg::LIN_ROM[ch[c]];
      end
    end
    if (rdy[ST_PROD]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r*3+k] <= pbg_pkg::PROD_W'(lin_r[k]) * pbg_pkg::PROD_W'(pbg_pkg::COEF[r*3+k]);
        end
      end
    end
    if (rdy[ST_COMP]) begin
      for (int r = 0; r < 3; r++) begin
        acc = pbg_pkg::ACC_W'(prod_r[r*3]) + pbg_pkg::ACC_W'(prod_r[r*3+1])
            + pbg_pkg::ACC_W'(prod_r[r*3+2]) + pbg_pkg::ACC_W'(128);
        comp_r[r] <= acc[pbg_pkg::ACC_W-1 -: pbg_pkg::COMP_W];
      end
    end
    if (rdy[ST_SQ]) begin
      for (int r = 0; r < 3; r++) begin
        sq_r[r] <= pbg_pkg::SQ_W'(comp_r[r]) * pbg_pkg::SQ_W'(comp_r[r]);
      end
    end
    if (rdy[ST_SUM]) begin
      sum_r <= pbg_pkg::S_W'(sq_r[0]) + pbg_pkg::S_W'(sq_r[1]) + pbg_pkg::S_W'(sq_r[2]);
    end
  end

  // The level compares the squared length against squared thresholds, so it
  // needs no root and travels alongside the square-root stages.
  always_comb begin
    level_nxt = 3'd0;
    for (int k = 0; k < pbg_pkg::N_LEVELS; k++) begin
      if (64'(sum_r) >= pbg_pkg::THRESH[k] * pbg_pkg::THRESH[k]) begin
        level_nxt = level_nxt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_ROOT0]) begin
      level_r[0] <= level_nxt;
    end
    for (int j = 1; j < pbg_pkg::SQ_STAGES; j++) begin
      if (rdy[ST_ROOT0+j]) begin
        level_r[j] <= level_r[j-1];
      end
    end
  end

  pbg_sqrt u_sqrt (
    .clk  (clk),
    .adv  (rdy[ST_ROOT0 +: pbg_pkg::SQ_STAGES]),
    .s_in (sum_r),
    .root (root)
  );

  always_comb begin
    rounded = (SUM_W'(root) + HALF) >> pbg_pkg::RND_SH;
    if (rounded > LIMIT) begin
      rounded = LIMIT;
    end
    out_nxt.brightness = rounded[pbg_pkg::BRIGHT_W-1:0];
    out_nxt.level      = level_r[pbg_pkg::SQ_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

endmodule
